// ----- sv/evpt_pkg.sv -----
// Shared constants and register codes for the encoder velocity/position tracker.
package evpt_pkg;

    // Field widths
    localparam int CNT_W   = 16;               // encoder counter reading
    localparam int ANG_W   = 48;               // Q32.16 position
    localparam int VEL_W   = 32;               // Q16.16 velocity
    localparam int SCALE_W = 32;               // Q16.16 scale factors
    localparam int RUN_W   = 16;               // still-sample run counter
    localparam int PROD_W  = CNT_W + SCALE_W;  // exact tick * scale product
    localparam int DIFF_W  = CNT_W + 3;        // raw difference plus wrap correction

    // Configuration port
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_COUNTER_TOP    = 2'd0,
        REG_VELOCITY_SCALE = 2'd1,
        REG_POSITION_SCALE = 2'd2,
        REG_REVERSE_DIR    = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic [CNT_W-1:0]   COUNTER_TOP_RST = '1;
    localparam logic [SCALE_W-1:0] VEL_SCALE_RST   = SCALE_W'(65536);
    localparam logic [SCALE_W-1:0] POS_SCALE_RST   = SCALE_W'(65536);

    // Input modes
    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

endpackage

// ----- sv/evpt_ifs.sv -----
// Valid/ready channel interfaces for tracker input items and result items.
interface evpt_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [evpt_pkg::CNT_W-1:0] counter_value;

    modport source (output valid, mode, counter_value, input ready);
    modport sink   (input valid, mode, counter_value, output ready);
endinterface

interface evpt_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [evpt_pkg::VEL_W-1:0] velocity;
    logic signed [evpt_pkg::ANG_W-1:0] position;
    logic signed [evpt_pkg::CNT_W-1:0] tick_change;
    logic        [evpt_pkg::RUN_W-1:0] still_samples;
    logic                              restarted;

    modport source (output valid, velocity, position, tick_change, still_samples, restarted,
                    input ready);
    modport sink   (input valid, velocity, position, tick_change, still_samples, restarted,
                    output ready);
endinterface

// ----- sv/encoder_velocity_position_tracker_top.sv -----
// Encoder tracker top level: wrap-corrected tick delta, velocity, position and still count.
//
// Each input item is a counter sample or a restart; each yields exactly one result item.
// The block is a four-register pipeline (input register, delta register, product register,
// result register) and takes one item per clock while the output side is ready, a rate set by
// the previous-count update in the delta stage and the saturating 48-bit position accumulate
// in the result stage. Each item goes from the input register through the delta, product and
// result registers in turn. Each stage holds its item while the next one is full, so input
// is still taken while a finished result waits on the output.
// Configuration is an APB-style port: counter_top at 0x0, velocity_scale at 0x4,
// position_scale at 0x8, reverse_direction at 0xC; write it only while the pipe is empty.
module encoder_velocity_position_tracker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    evpt_in_if.sink                       i_in,
    evpt_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [evpt_pkg::APB_AW-1:0]   paddr,
    input  logic [evpt_pkg::APB_DW-1:0]   pwdata,
    output logic [evpt_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CNT_W   = evpt_pkg::CNT_W;
    localparam int ANG_W   = evpt_pkg::ANG_W;
    localparam int VEL_W   = evpt_pkg::VEL_W;
    localparam int SCALE_W = evpt_pkg::SCALE_W;
    localparam int RUN_W   = evpt_pkg::RUN_W;
    localparam int PROD_W  = evpt_pkg::PROD_W;
    localparam int DIFF_W  = evpt_pkg::DIFF_W;
    localparam int APB_DW  = evpt_pkg::APB_DW;

    localparam logic signed [DIFF_W-1:0] TICK_MAX = DIFF_W'((1 << (CNT_W-1)) - 1);
    localparam logic signed [DIFF_W-1:0] TICK_MIN = -DIFF_W'(1 << (CNT_W-1));
    localparam logic signed [PROD_W-1:0] VEL_MAX  = PROD_W'((64'sd1 << (VEL_W-1)) - 1);
    localparam logic signed [PROD_W-1:0] VEL_MIN  = -PROD_W'(64'sd1 << (VEL_W-1));

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]   r_counter_top;
    logic [SCALE_W-1:0] r_velocity_scale;
    logic [SCALE_W-1:0] r_position_scale;
    logic               r_reverse_dir;
    evpt_pkg::t_reg_idx w_reg_idx;
    logic               w_cfg_wr;

    assign w_reg_idx = evpt_pkg::t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter_top    <= evpt_pkg::COUNTER_TOP_RST;
            r_velocity_scale <= evpt_pkg::VEL_SCALE_RST;
            r_position_scale <= evpt_pkg::POS_SCALE_RST;
            r_reverse_dir    <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                evpt_pkg::REG_COUNTER_TOP:    r_counter_top    <= pwdata[CNT_W-1:0];
                evpt_pkg::REG_VELOCITY_SCALE: r_velocity_scale <= pwdata[SCALE_W-1:0];
                evpt_pkg::REG_POSITION_SCALE: r_position_scale <= pwdata[SCALE_W-1:0];
                evpt_pkg::REG_REVERSE_DIR:    r_reverse_dir    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (w_reg_idx)
            evpt_pkg::REG_COUNTER_TOP:    prdata = APB_DW'(r_counter_top);
            evpt_pkg::REG_VELOCITY_SCALE: prdata = APB_DW'(r_velocity_scale);
            evpt_pkg::REG_POSITION_SCALE: prdata = APB_DW'(r_position_scale);
            evpt_pkg::REG_REVERSE_DIR:    prdata = APB_DW'(r_reverse_dir);
            default:                      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its item moves on
    // ---------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic w_s1_en, w_s2_en, w_s3_en, w_out_en;

    assign w_out_en   = !r_out_valid || o_out.ready;
    assign w_s3_en    = !r_s3_valid  || w_out_en;
    assign w_s2_en    = !r_s2_valid  || w_s3_en;
    assign w_s1_en    = !r_s1_valid  || w_s2_en;
    assign i_in.ready = w_s1_en;

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic             r_s1_restart;
    logic [CNT_W-1:0] r_s1_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en && i_in.valid) begin
            r_s1_restart <= (i_in.mode == evpt_pkg::MODE_RESTART);
            r_s1_count   <= i_in.counter_value;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: wrap-corrected, direction-applied, clamped tick change
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]         r_prev_count;
    logic                     r_awaiting_first;
    logic                     r_s2_restart;
    logic signed [CNT_W-1:0]  r_s2_delta;
    logic signed [DIFF_W-1:0] w_diff, w_half, w_mod, w_adj, w_dir;
    logic signed [CNT_W-1:0]  w_delta;

    assign w_diff = $signed(DIFF_W'(r_s1_count)) - $signed(DIFF_W'(r_prev_count));
    assign w_half = $signed(DIFF_W'(r_counter_top >> 1));
    assign w_mod  = $signed(DIFF_W'(r_counter_top)) + DIFF_W'(1);

    always_comb begin
        // a rise past half the range or a fall of at least half is a wrap
        if (r_awaiting_first) begin
            w_adj = '0;
        end else if (w_diff > 0 && w_diff > w_half) begin
            w_adj = w_diff - w_mod;
        end else if (w_diff < 0 && -w_diff >= w_half) begin
            w_adj = w_diff + w_mod;
        end else begin
            w_adj = w_diff;
        end
        w_dir = r_reverse_dir ? -w_adj : w_adj;
        if (w_dir > TICK_MAX) begin
            w_delta = TICK_MAX[CNT_W-1:0];
        end else if (w_dir < TICK_MIN) begin
            w_delta = TICK_MIN[CNT_W-1:0];
        end else begin
            w_delta = w_dir[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid       <= 1'b0;
            r_prev_count     <= '0;
            r_awaiting_first <= 1'b1;
        end else if (w_s2_en) begin
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_prev_count     <= r_s1_restart ? '0 : r_s1_count;
                r_awaiting_first <= r_s1_restart;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_en && r_s1_valid) begin
            r_s2_restart <= r_s1_restart;
            r_s2_delta   <= r_s1_restart ? '0 : w_delta;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: velocity and angle-step products
    // ---------------------------------------------------------------
    logic                     r_s3_restart;
    logic signed [CNT_W-1:0]  r_s3_delta;
    logic signed [PROD_W-1:0] r_s3_vprod, r_s3_step;
    logic signed [PROD_W-1:0] w_vprod, w_step;

    assign w_vprod = $signed(r_s2_delta) * $signed({1'b0, r_velocity_scale});
    assign w_step  = $signed(r_s2_delta) * $signed({1'b0, r_position_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s3_en && r_s2_valid) begin
            r_s3_restart <= r_s2_restart;
            r_s3_delta   <= r_s2_delta;
            r_s3_vprod   <= w_vprod;
            r_s3_step    <= w_step;
        end
    end

    // ---------------------------------------------------------------
    // Result stage: velocity clamp, saturating position, still run
    // ---------------------------------------------------------------
    logic signed [ANG_W-1:0] r_angle_total;
    logic [RUN_W-1:0]        r_still_run;
    logic signed [VEL_W-1:0] r_out_velocity;
    logic signed [CNT_W-1:0] r_out_tick;
    logic                    r_out_restarted;
    logic signed [ANG_W:0]   w_sum;
    logic signed [ANG_W-1:0] n_angle_total;
    logic [RUN_W-1:0]        n_still_run;
    logic signed [VEL_W-1:0] w_vel;

    assign w_sum = $signed((ANG_W+1)'(r_angle_total)) + $signed((ANG_W+1)'(r_s3_step));

    always_comb begin
        // velocity clamp to the signed Q16.16 range
        if (r_s3_vprod > VEL_MAX) begin
            w_vel = VEL_MAX[VEL_W-1:0];
        end else if (r_s3_vprod < VEL_MIN) begin
            w_vel = VEL_MIN[VEL_W-1:0];
        end else begin
            w_vel = r_s3_vprod[VEL_W-1:0];
        end

        // position saturates when the sum leaves the signed range
        if (w_sum[ANG_W] != w_sum[ANG_W-1]) begin
            n_angle_total = w_sum[ANG_W] ? {1'b1, {(ANG_W-1){1'b0}}}
                                         : {1'b0, {(ANG_W-1){1'b1}}};
        end else begin
            n_angle_total = w_sum[ANG_W-1:0];
        end

        // run of zero-velocity samples, held at full scale
        if (r_s3_vprod != '0) begin
            n_still_run = '0;
        end else if (r_still_run == '1) begin
            n_still_run = r_still_run;
        end else begin
            n_still_run = r_still_run + RUN_W'(1);
        end

        if (r_s3_restart) begin
            n_angle_total = '0;
            n_still_run   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_angle_total <= '0;
            r_still_run   <= '0;
        end else if (w_out_en) begin
            r_out_valid <= r_s3_valid;
            if (r_s3_valid) begin
                r_angle_total <= n_angle_total;
                r_still_run   <= n_still_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && r_s3_valid) begin
            r_out_velocity  <= r_s3_restart ? '0 : w_vel;
            r_out_tick      <= r_s3_delta;
            r_out_restarted <= r_s3_restart;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.velocity      = r_out_velocity;
    assign o_out.position      = r_angle_total;
    assign o_out.tick_change   = r_out_tick;
    assign o_out.still_samples = r_still_run;
    assign o_out.restarted     = r_out_restarted;

endmodule

// ----- sv/evpt_checker.sv -----
// Port-level assertions for the encoder tracker, bound to the top level.
module evpt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic signed [evpt_pkg::VEL_W-1:0] i_velocity,
    input logic signed [evpt_pkg::ANG_W-1:0] i_position,
    input logic signed [evpt_pkg::CNT_W-1:0] i_tick_change,
    input logic        [evpt_pkg::RUN_W-1:0] i_still_samples,
    input logic                              i_restarted
);

    // no result is shown in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a restart answer carries all-zero fields
    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_restarted |->
            i_velocity == '0 && i_position == '0 && i_tick_change == '0
            && i_still_samples == '0)
        else $error("restart result not cleared");

    // a sample result counts a still run exactly when velocity is zero
    a_still_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_restarted |-> (i_velocity == '0) == (i_still_samples != '0))
        else $error("still count disagrees with velocity");

    // no tick change means no velocity
    a_zero_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_tick_change == '0 |-> i_velocity == '0)
        else $error("velocity without tick change");

endmodule

bind encoder_velocity_position_tracker_top evpt_checker u_evpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_velocity      (o_out.velocity),
    .i_position      (o_out.position),
    .i_tick_change   (o_out.tick_change),
    .i_still_samples (o_out.still_samples),
    .i_restarted     (o_out.restarted)
);

// ----- tb/sv/evpt_checker.sv -----
// Checker for the encoder tracker: watches both channels and the register port, predicts, compares.
module tb_evpt_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    evpt_in_if                         in_mon,
    evpt_out_if                        out_mon,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [evpt_pkg::APB_AW-1:0] i_paddr,
    input  logic [evpt_pkg::APB_DW-1:0] i_pwdata,
    output int                         o_errors,
    output int                         o_pending
);

    localparam longint ANG_HI = (longint'(1) << (evpt_pkg::ANG_W - 1)) - 1;
    localparam longint ANG_LO = -ANG_HI - 1;
    localparam longint VEL_HI = (longint'(1) << (evpt_pkg::VEL_W - 1)) - 1;
    localparam longint VEL_LO = -VEL_HI - 1;
    localparam longint TICK_HI = (longint'(1) << (evpt_pkg::CNT_W - 1)) - 1;
    localparam longint TICK_LO = -TICK_HI - 1;

    typedef struct packed {
        logic signed [evpt_pkg::VEL_W-1:0] velocity;
        logic signed [evpt_pkg::ANG_W-1:0] position;
        logic signed [evpt_pkg::CNT_W-1:0] tick_change;
        logic        [evpt_pkg::RUN_W-1:0] still_samples;
        logic                              restarted;
    } t_track_result;

    // Register copies
    logic [evpt_pkg::CNT_W-1:0]   cfg_counter_top;
    logic [evpt_pkg::SCALE_W-1:0] cfg_vel_scale;
    logic [evpt_pkg::SCALE_W-1:0] cfg_pos_scale;
    logic                         cfg_reverse;

    // Tracker state copies
    logic [evpt_pkg::CNT_W-1:0]   last_count;
    logic                         first_pending;
    longint                       angle_sum;
    logic [evpt_pkg::RUN_W-1:0]   still_count;

    t_track_result                expected_results[$];
    int                           mismatch_count;

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the tracker copy by one item and return the result it must produce
    function automatic t_track_result track_item(input logic item_mode,
                                                 input logic [evpt_pkg::CNT_W-1:0] item_count);
        t_track_result res;
        longint cur, prev, half, modulus, delta, vel, ang_step, vscale, pscale;
        res = '0;
        if (item_mode == evpt_pkg::MODE_RESTART) begin
            angle_sum     = 0;
            last_count    = '0;
            first_pending = 1'b1;
            still_count   = '0;
            res.restarted = 1'b1;
            return res;
        end
        cur     = item_count;
        prev    = last_count;
        half    = cfg_counter_top / 2;
        modulus = longint'(cfg_counter_top) + 1;
        delta   = 0;
        // wrap test is asymmetric: strict for rises, inclusive for falls
        if (first_pending) begin
            delta = 0;
        end else if (cur > prev) begin
            delta = cur - prev;
            if (delta > half) delta -= modulus;
        end else if (cur < prev) begin
            delta = cur - prev;
            if (prev - cur >= half) delta += modulus;
        end
        if (cfg_reverse) delta = -delta;
        delta         = clamp_range(delta, TICK_LO, TICK_HI);
        last_count    = item_count;
        first_pending = 1'b0;

        vscale   = cfg_vel_scale;
        pscale   = cfg_pos_scale;
        vel      = clamp_range(delta * vscale, VEL_LO, VEL_HI);
        ang_step = delta * pscale;

        // saturating position accumulate
        if (ang_step > 0 && angle_sum > ANG_HI - ang_step) angle_sum = ANG_HI;
        else if (ang_step < 0 && angle_sum < ANG_LO - ang_step) angle_sum = ANG_LO;
        else angle_sum += ang_step;

        if (vel == 0) begin
            if (still_count != '1) still_count++;
        end else begin
            still_count = '0;
        end

        res.velocity      = evpt_pkg::VEL_W'(vel);
        res.position      = evpt_pkg::ANG_W'(angle_sum);
        res.tick_change   = evpt_pkg::CNT_W'(delta);
        res.still_samples = still_count;
        res.restarted     = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Compare one result item with the oldest prediction
    task automatic check_result(input t_track_result got);
        t_track_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result item with no prediction waiting");
            return;
        end
        want = expected_results.pop_front();
        if (got.velocity !== want.velocity)
            report_mismatch($sformatf("velocity got %0d want %0d", got.velocity, want.velocity));
        if (got.position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d", got.position, want.position));
        if (got.tick_change !== want.tick_change)
            report_mismatch($sformatf("tick_change got %0d want %0d",
                                      got.tick_change, want.tick_change));
        if (got.still_samples !== want.still_samples)
            report_mismatch($sformatf("still_samples got %0d want %0d",
                                      got.still_samples, want.still_samples));
        if (got.restarted !== want.restarted)
            report_mismatch($sformatf("restarted got %0b want %0b",
                                      got.restarted, want.restarted));
    endtask

    initial begin
        mismatch_count = 0;
        o_errors       = 0;
        o_pending      = 0;
    end

    always @(posedge i_clk) begin
        t_track_result seen;
        if (!i_rst_n) begin
            cfg_counter_top = evpt_pkg::COUNTER_TOP_RST;
            cfg_vel_scale   = evpt_pkg::VEL_SCALE_RST;
            cfg_pos_scale   = evpt_pkg::POS_SCALE_RST;
            cfg_reverse     = 1'b0;
            last_count      = '0;
            first_pending   = 1'b1;
            angle_sum       = 0;
            still_count     = '0;
            expected_results.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (evpt_pkg::t_reg_idx'(i_paddr[3:2]))
                    evpt_pkg::REG_COUNTER_TOP:
                        cfg_counter_top = i_pwdata[evpt_pkg::CNT_W-1:0];
                    evpt_pkg::REG_VELOCITY_SCALE:
                        cfg_vel_scale   = i_pwdata[evpt_pkg::SCALE_W-1:0];
                    evpt_pkg::REG_POSITION_SCALE:
                        cfg_pos_scale   = i_pwdata[evpt_pkg::SCALE_W-1:0];
                    evpt_pkg::REG_REVERSE_DIR:
                        cfg_reverse     = i_pwdata[0];
                    default: ;
                endcase
            end
            // accepted input item
            if (in_mon.valid && in_mon.ready)
                expected_results.push_back(track_item(in_mon.mode, in_mon.counter_value));
            // accepted result item
            if (out_mon.valid && out_mon.ready) begin
                seen.velocity      = out_mon.velocity;
                seen.position      = out_mon.position;
                seen.tick_change   = out_mon.tick_change;
                seen.still_samples = out_mon.still_samples;
                seen.restarted     = out_mon.restarted;
                check_result(seen);
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_results.size();
    end

endmodule

// ----- tb/sv/tb_encoder_velocity_position_tracker_top.sv -----
// Testbench top for the encoder tracker: clock, reset, stimulus, register writes and verdict.
module tb_encoder_velocity_position_tracker_top;

    localparam int HOLD_CYCLES = 300;
    localparam int WALK_ITEMS  = 50;
    localparam int WALK_PHASES = 8;
    localparam int STILL_ITEMS = 20;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [evpt_pkg::APB_AW-1:0]  paddr;
    logic [evpt_pkg::APB_DW-1:0]  pwdata;
    logic [evpt_pkg::APB_DW-1:0]  prdata;
    logic                         pready;

    int                           fail_count;
    int                           pending_count;
    int                           tx_idle_pct;
    int                           rx_stall_pct;
    logic                         hold_req;
    logic                         hold_done;
    logic [evpt_pkg::CNT_W-1:0]   cur_top;
    longint                       enc_pos;

    evpt_in_if  in_ch ();
    evpt_out_if out_ch ();

    encoder_velocity_position_tracker_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_evpt_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (fail_count),
        .o_pending (pending_count)
    );

    // 10-unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_encoder_velocity_position_tracker_top: FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one item and hold it until taken
    task automatic send_item(input logic item_mode, input logic [evpt_pkg::CNT_W-1:0] item_count);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= item_mode;
        in_ch.counter_value <= item_count;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup cycle, access cycle, then the bus returns to idle
    task automatic write_reg(input evpt_pkg::t_reg_idx idx,
                             input logic [evpt_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_tracker(input logic [evpt_pkg::CNT_W-1:0] top,
                                   input logic [evpt_pkg::SCALE_W-1:0] vs,
                                   input logic [evpt_pkg::SCALE_W-1:0] ps, input logic rev);
        write_reg(evpt_pkg::REG_COUNTER_TOP, evpt_pkg::APB_DW'(top));
        write_reg(evpt_pkg::REG_VELOCITY_SCALE, evpt_pkg::APB_DW'(vs));
        write_reg(evpt_pkg::REG_POSITION_SCALE, evpt_pkg::APB_DW'(ps));
        write_reg(evpt_pkg::REG_REVERSE_DIR, evpt_pkg::APB_DW'(rev));
        cur_top = top;
    endtask

    // Mostly a plausible encoder walk, with restarts and noise readings mixed in
    task automatic send_encoder_walk(input int count);
        int unsigned pick;
        longint      span;
        longint      move;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            span = longint'(cur_top) + 1;
            if (pick < 4) begin
                send_item(evpt_pkg::MODE_RESTART, evpt_pkg::CNT_W'($urandom));
            end else if (pick < 12) begin
                enc_pos = longint'(evpt_pkg::CNT_W'($urandom));
                send_item(evpt_pkg::MODE_SAMPLE, evpt_pkg::CNT_W'(enc_pos));
            end else begin
                if (pick < 70) move = longint'($urandom_range(128)) - 64;
                else if (pick < 90)
                    move = longint'($urandom_range(cur_top + 2)) - (longint'(cur_top) / 2 + 1);
                else move = 0;
                enc_pos = (((enc_pos + move) % span) + span) % span;
                send_item(evpt_pkg::MODE_SAMPLE, evpt_pkg::CNT_W'(enc_pos));
            end
        end
    endtask

    task automatic pick_random_config();
        logic [evpt_pkg::CNT_W-1:0]   top;
        logic [evpt_pkg::SCALE_W-1:0] vs;
        logic [evpt_pkg::SCALE_W-1:0] ps;
        case ($urandom_range(3))
            0: top = '1;
            1: top = evpt_pkg::CNT_W'($urandom);
            2: top = evpt_pkg::CNT_W'($urandom_range(300, 2));
            default: top = evpt_pkg::CNT_W'($urandom_range(3));
        endcase
        case ($urandom_range(3))
            0: vs = $urandom;
            1: vs = $urandom_range(1 << 18);
            2: vs = evpt_pkg::VEL_SCALE_RST;
            default: vs = '0;
        endcase
        case ($urandom_range(3))
            0: ps = $urandom;
            1: ps = $urandom_range(1 << 18);
            2: ps = '1;
            default: ps = evpt_pkg::POS_SCALE_RST;
        endcase
        program_tracker(top, vs, ps, 1'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.mode          <= evpt_pkg::MODE_SAMPLE;
        in_ch.counter_value <= '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        cur_top      = evpt_pkg::COUNTER_TOP_RST;
        enc_pos      = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first sample, both wrap edges, restart
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd100);
        send_item(evpt_pkg::MODE_SAMPLE, 16'hFFFF);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd32767);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd32768);
        send_item(evpt_pkg::MODE_RESTART, 16'hFFFF);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd5);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd5);
        wait_drained();

        // Full scales, reversed: velocity clamps, position runs into its low limit
        program_tracker('1, '1, '1, 1'b1);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd32767);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd32767);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        wait_drained();
        // forward again: climb to the high limit
        write_reg(evpt_pkg::REG_REVERSE_DIR, '0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd32767);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd32767);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd32767);
        wait_drained();

        // Counter top zero and zero velocity scale
        program_tracker('0, '0, 32'd1, 1'b0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd5);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd0);
        send_item(evpt_pkg::MODE_SAMPLE, 16'd7);
        wait_drained();

        // Still run with zero velocity scale, full rate
        program_tracker('1, '0, 32'd1, 1'b0);
        for (int k = 0; k < STILL_ITEMS; k++)
            send_item(evpt_pkg::MODE_SAMPLE, evpt_pkg::CNT_W'($urandom));
        wait_drained();

        // Random phases cycling through the idling patterns
        for (int ph = 0; ph < WALK_PHASES; ph++) begin
            pick_random_config();
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase
            // back-pressure: result side holds off while items keep coming
            if (ph == 0) hold_req = 1'b1;
            send_encoder_walk(WALK_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_encoder_velocity_position_tracker_top: PASS");
        end else begin
            $display("tb_encoder_velocity_position_tracker_top: FAIL");
        end
        $finish;
    end

endmodule
